@@ rtl/core/bsfd_pkg.sv @@
// Shared types and constants for the byte-stuffing frame decoder.
package bsfd_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int KIND_W      = 2;
  localparam int ERR_W       = 2;
  localparam int OUT_DATA_W  = 24;  // data_byte + error_code + frame_length, byte padded
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    MODE_HUNT    = 2'd0,
    MODE_FRAME   = 2'd1,
    MODE_DISCARD = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NO_START       = 2'd0,
    ERR_START_IN_FRAME = 2'd1,
    ERR_EMPTY          = 2'd2,
    ERR_TOO_LONG       = 2'd3
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START = 2'd0,
    REG_SHIFT = 2'd1,
    REG_STOP  = 2'd2
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] START_RST = 8'd240;
  localparam logic [BYTE_W-1:0] SHIFT_RST = 8'd241;
  localparam logic [BYTE_W-1:0] STOP_RST  = 8'd242;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] shift_code;
    logic [BYTE_W-1:0] stop_code;
  } codes_t;

  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    err_t              error_code;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage

@@ rtl/core/bsfd_cfg_regs.sv @@
// Configuration register file holding the start, shift and stop codes.
module bsfd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsfd_pkg::BYTE_W-1:0]    cfg_data,
  output bsfd_pkg::codes_t               codes
);
  import bsfd_pkg::*;

  codes_t codes_r;
  codes_t codes_nxt;

  assign cfg_ready = 1'b1;
  assign codes     = codes_r;

  always_comb begin
    codes_nxt = codes_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START: codes_nxt.start_code = cfg_data;
        REG_SHIFT: codes_nxt.shift_code = cfg_data;
        REG_STOP:  codes_nxt.stop_code  = cfg_data;
        default:   codes_nxt = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.start_code <= START_RST;
      codes_r.shift_code <= SHIFT_RST;
      codes_r.stop_code  <= STOP_RST;
    end else begin
      codes_r <= codes_nxt;
    end
  end

endmodule

@@ rtl/core/bsfd_parser.sv @@
// Per-byte deframing state machine: mode, escape flag and payload count.
module bsfd_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_vld,
  input  logic [bsfd_pkg::BYTE_W-1:0] rx_byte,
  input  bsfd_pkg::codes_t            codes,
  output bsfd_pkg::result_t           res
);
  import bsfd_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic is_shift, is_start, is_stop, at_max;

  assign is_shift = (rx_byte == codes.shift_code);
  assign is_start = (rx_byte == codes.start_code);
  assign is_stop  = (rx_byte == codes.stop_code);
  assign at_max   = (cnt_r >= CNT_W'(MAX_PAYLOAD));

  // next state
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    if (byte_vld) begin
      case (mode_r)
        MODE_FRAME: begin
          if (is_shift) begin
            esc_nxt = 1'b1;
          end else if (is_start) begin
            mode_nxt = MODE_DISCARD;
          end else if (is_stop || at_max) begin
            mode_nxt = MODE_HUNT;
          end else begin
            esc_nxt = 1'b0;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        MODE_DISCARD: begin
          if (is_stop) mode_nxt = MODE_HUNT;
        end
        default: begin
          if (is_start) begin
            mode_nxt = MODE_FRAME;
            cnt_nxt  = '0;
            esc_nxt  = 1'b0;
          end else begin
            mode_nxt = is_stop ? MODE_HUNT : MODE_DISCARD;
          end
        end
      endcase
    end
  end

  // result for this byte
  always_comb begin
    res              = '0;
    res.kind         = KIND_DATA;
    res.error_code   = ERR_NO_START;
    if (byte_vld) begin
      case (mode_r)
        MODE_FRAME: begin
          if (is_shift) begin
            res.vld = 1'b0;
          end else if (is_start) begin
            res.vld        = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_START_IN_FRAME;
          end else if (is_stop) begin
            res.vld = 1'b1;
            if (cnt_r == '0) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_EMPTY;
            end else begin
              res.kind         = KIND_END;
              res.frame_length = LEN_W'(cnt_r);
            end
          end else if (at_max) begin
            res.vld        = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TOO_LONG;
          end else begin
            res.vld       = 1'b1;
            res.data_byte = esc_r ? (rx_byte + codes.start_code) : rx_byte;
          end
        end
        MODE_DISCARD: res.vld = 1'b0;
        default: begin
          if (!is_start) begin
            res.vld  = 1'b1;
            res.kind = KIND_ERROR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HUNT;
      esc_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/bsfd_out_buf.sv @@
// Two-entry result register with skid slot, decoupling input from output stalls.
module bsfd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bsfd_pkg::result_t push_res,
  output logic              space,
  output logic              out_vld,
  input  logic              out_rdy,
  output bsfd_pkg::result_t out_res
);
  import bsfd_pkg::*;

  result_t    ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign space   = (cnt_r != 2'd2);
  assign out_vld = (cnt_r != 2'd0);
  assign out_res = ent_r[rptr_r];
  assign pop     = out_vld && out_rdy;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/byte_stuffing_frame_decoder.sv @@
// Top level of the byte-stuffing frame decoder.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in_      | in_tvalid / in_tready  | in_tdata[7:0] rx_byte
//  out_     | out_tvalid / out_tready| out_tdata data_byte, error_code, frame_length
//           |                        | out_tuser out_kind
//  cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte per cycle while in_tready is high. Each accepted byte is decoded in the
// same cycle it is taken and its result (if any) is registered in a two-entry
// output buffer that drives out_. in_tready drops only when both buffer entries
// are full. Reset (synchronous, rst_n low) returns to hunting with default codes.
module byte_stuffing_frame_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bsfd_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bsfd_pkg::OUT_DATA_W-1:0]     out_tdata,  // [7:0] data_byte, [9:8] error_code,
                                                          // [16:10] frame_length, [23:17] zero
  output logic [bsfd_pkg::KIND_W-1:0]         out_tuser,  // [1:0] out_kind
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsfd_pkg::BYTE_W-1:0]         cfg_data
);
  import bsfd_pkg::*;

  codes_t  codes;
  result_t res;
  result_t head;
  logic    space;
  logic    in_xfer;

  assign in_tready = space;
  assign in_xfer   = in_tvalid && space;

  bsfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes)
  );

  bsfd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_xfer),
    .rx_byte  (in_tdata),
    .codes    (codes),
    .res      (res)
  );

  bsfd_out_buf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res.vld),
    .push_res (res),
    .space    (space),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_res  (head)
  );

  assign out_tdata = {{(OUT_DATA_W - BYTE_W - ERR_W - LEN_W){1'b0}},
                      head.frame_length, head.error_code, head.data_byte};
  assign out_tuser = head.kind;

endmodule

@@ rtl/core/bsfd_checker.sv @@
// Port-level checks for the frame decoder, bound to the top level.
module bsfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("unused kind code on output");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'd0 |-> out_tdata[23:8] == 16'd0)
    else $error("data result carries error or length bits");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'd2 |-> out_tdata[7:0] == 8'd0 && out_tdata[23:10] == 14'd0)
    else $error("error result carries data or length bits");

endmodule

bind byte_stuffing_frame_decoder bsfd_checker u_bsfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
